@@ sv/arpr_pkg.sv @@
// Shared types, codes and constants of the ARP responder with address cache.
// Used by arpr_classify and arp_responder_with_cache; no dependencies.
`default_nettype none
package arpr_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

	localparam int IN_TDATA_W  = 248;
	localparam int OUT_TDATA_W = 184;
	localparam int CFG_DATA_W  = 48;

	// item kinds
	localparam logic [1:0] OP_FRAME   = 2'd0;
	localparam logic [1:0] OP_LOOKUP  = 2'd1;
	localparam logic [1:0] OP_REQUEST = 2'd2;
	localparam logic [1:0] OP_FLUSH   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SENT = 3'd1;
	localparam logic [2:0] ST_HIT  = 3'd2;
	localparam logic [2:0] ST_MISS = 3'd3;
	localparam logic [2:0] ST_OFF  = 3'd4;

	// register indexes
	localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
	localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
	localparam logic [1:0] CFG_ENABLED   = 2'd2;

	localparam logic [31:0] LOCAL_IP_RST  = 32'h0A00_0002;
	localparam logic [47:0] LOCAL_MAC_RST = 48'h0200_0000_0002;

	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [15:0] HTYPE_ETH     = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
	localparam logic [7:0]  HLEN_ETH      = 8'd6;
	localparam logic [7:0]  PLEN_IPV4     = 8'd4;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
	localparam logic [1:0]  OUT_OP_NONE   = 2'd0;
	localparam logic [1:0]  OUT_OP_REQ    = 2'd1;
	localparam logic [1:0]  OUT_OP_REPLY  = 2'd2;
	localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [47:0] frame_source_mac;
		logic [31:0] tgt_ip;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [15:0] arp_op;
		logic [7:0]  protocol_length;
		logic [7:0]  hardware_length;
		logic [15:0] protocol_type;
		logic [15:0] hardware_type;
		logic [15:0] ether_type;
		logic        frame_too_short;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] lookup_mac;
		logic [31:0] out_target_ip;
		logic [47:0] out_target_mac;
		logic [1:0]  out_arp_op;
		logic [47:0] out_dest_mac;
		logic        send_frame;
	} result_t;

	typedef enum logic [1:0] {
		ACT_DONE,
		ACT_LEARN,
		ACT_LOOKUP,
		ACT_FLUSH
	} act_t;

	typedef struct packed {
		act_t        act;
		logic [31:0] key_ip;
		logic [47:0] mac;
		result_t     res;
	} plan_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ sv/arp_responder_with_cache.sv @@
// Top level: ARP responder with a 16-entry IP-to-MAC cache held in one RAM.
// Depends on arpr_pkg, arpr_classify and arpr_ram.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser operation, s_tdata frame fields
//  m_*      out  m_tvalid/m_tready  m_tuser status, m_tdata result fields
//  cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// Lookup and learning scan the cache RAM one entry per cycle; other items
// skip the scan and go straight to the result state.
// The scan stops early on an IP match. Reset clears all valid bits at once.
// A new item is taken while the previous result waits in the output register;
// the block stalls only when a finished result finds that register still full.
`default_nettype none
module arp_responder_with_cache (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// frame_too_short, ether_type, hardware_type, protocol_type,
	// hardware_length, protocol_length, arp_op, sender_mac, sender_ip,
	// tgt_ip, frame_source_mac, zero fill
	input  wire logic [arpr_pkg::IN_TDATA_W-1:0] s_tdata,
	// operation
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// send_frame, out_dest_mac, out_arp_op, out_target_mac, out_target_ip,
	// lookup_mac, zero fill
	output logic [arpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// status
	output logic [2:0]                           m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [arpr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import arpr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

	state_t state_q;

	logic [31:0] host_ip_q;
	logic [47:0] host_mac_q;
	logic        enabled_q;

	item_t   item;
	plan_t   plan;
	plan_t   plan_q;
	result_t out_q;
	logic    m_tvalid_q;

	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]         rd_cnt_q;
	logic [IDX_W-1:0]         rd_idx;
	logic                     p_s1;
	logic                     ev_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_idx_q;

	entry_t           rd_ent;
	logic [ENTRY_W-1:0] rd_data;
	logic             s_xfer;
	logic             rd_more;
	logic             match;
	logic             scan_end;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             out_free;

	assign item = s_tdata[$bits(item_t)-1:0];

	arpr_classify u_classify (
		.operation (s_tuser),
		.item      (item),
		.host_ip   (host_ip_q),
		.enabled   (enabled_q),
		.plan      (plan)
	);

	arpr_ram #(
		.DEPTH (CACHE_ENTRIES),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata ({plan_q.key_ip, plan_q.mac}),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	always_comb begin
		rd_ent   = rd_data;
		rd_idx   = rd_cnt_q[IDX_W-1:0];
		rd_more  = rd_cnt_q != CNT_END;
		s_tready = state_q == S_IDLE;
		s_xfer   = s_tvalid && s_tready;
		out_free = !m_tvalid_q || m_tready;
		match    = p_s1 && ev_s1 && rd_ent.ip == plan_q.key_ip;
		scan_end = state_q == S_SCAN && (match || (p_s1 && idx_s1 == LAST_IDX));
		wr_en    = scan_end && plan_q.act == ACT_LEARN;
		if (match) begin
			wr_idx = idx_s1;
		end else if (free_found_q) begin
			wr_idx = free_idx_q;
		end else if (!ev_s1) begin
			wr_idx = idx_s1;
		end else begin
			wr_idx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_ip_q  <= LOCAL_IP_RST;
			host_mac_q <= LOCAL_MAC_RST;
			enabled_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOCAL_IP:  host_ip_q  <= cfg_data[31:0];
				CFG_LOCAL_MAC: host_mac_q <= cfg_data[47:0];
				CFG_ENABLED:   enabled_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_tvalid_q   <= 1'b0;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			p_s1         <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (state_q == S_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						rd_cnt_q     <= '0;
						p_s1         <= 1'b0;
						free_found_q <= 1'b0;
						if (plan.act == ACT_FLUSH) begin
							valid_q <= '0;
						end
						if (plan.act == ACT_LEARN || plan.act == ACT_LOOKUP) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_SCAN: begin
					p_s1 <= rd_more;
					if (rd_more) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (p_s1 && !ev_s1) begin
						free_found_q <= 1'b1;
					end
					if (wr_en) begin
						valid_q[wr_idx] <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			plan_q <= plan;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= rd_idx;
			ev_s1  <= rd_more ? valid_q[rd_idx] : 1'b1;
			if (p_s1 && !ev_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (scan_end && plan_q.act == ACT_LOOKUP && match) begin
				plan_q.res.status     <= ST_HIT;
				plan_q.res.lookup_mac <= rd_ent.mac;
			end
		end
		if (state_q == S_RESULT && out_free) begin
			out_q <= plan_q.res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.lookup_mac, out_q.out_target_ip, out_q.out_target_mac,
		out_q.out_arp_op, out_q.out_dest_mac, out_q.send_frame};

endmodule
`default_nettype wire

@@ sv/arpr_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the address cache entries.
`default_nettype none
module arpr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 80,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/arpr_classify.sv @@
// Decodes one input item: header checks, action to take and the result fields
// known before any cache access. Depends on arpr_pkg.
`default_nettype none
module arpr_classify (
	input  wire logic [1:0]     operation,
	input  wire arpr_pkg::item_t item,
	input  wire logic [31:0]    host_ip,
	input  wire logic           enabled,
	output arpr_pkg::plan_t     plan
);
	import arpr_pkg::*;

	logic hdr_ok;
	logic is_req;
	logic is_reply;

	always_comb begin
		hdr_ok = !item.frame_too_short
			&& item.ether_type == ETHERTYPE_ARP
			&& item.hardware_type == HTYPE_ETH
			&& item.protocol_type == PTYPE_IPV4
			&& item.hardware_length == HLEN_ETH
			&& item.protocol_length == PLEN_IPV4;
		is_req   = item.arp_op == ARP_OP_REQ;
		is_reply = item.arp_op == ARP_OP_REPLY;

		plan        = '0;
		plan.act    = ACT_DONE;
		plan.key_ip = item.tgt_ip;
		plan.mac    = item.sender_mac;
		plan.res.status = ST_IDLE;

		case (operation)
			OP_FRAME: begin
				plan.key_ip = item.sender_ip;
				if (!enabled) begin
					plan.res.status = ST_OFF;
				end else if (hdr_ok && (is_req || is_reply)) begin
					plan.act = ACT_LEARN;
					if (is_req && item.tgt_ip == host_ip) begin
						plan.res.status         = ST_SENT;
						plan.res.send_frame     = 1'b1;
						plan.res.out_dest_mac   = item.frame_source_mac;
						plan.res.out_arp_op     = OUT_OP_REPLY;
						plan.res.out_target_mac = item.sender_mac;
						plan.res.out_target_ip  = item.sender_ip;
					end
				end
			end
			OP_LOOKUP: begin
				plan.act        = ACT_LOOKUP;
				plan.res.status = ST_MISS;
			end
			OP_REQUEST: begin
				plan.res.status        = ST_SENT;
				plan.res.send_frame    = 1'b1;
				plan.res.out_dest_mac  = MAC_BCAST;
				plan.res.out_arp_op    = OUT_OP_REQ;
				plan.res.out_target_ip = item.tgt_ip;
			end
			OP_FLUSH: begin
				plan.act = ACT_FLUSH;
			end
			default: begin
				plan.act = ACT_DONE;
			end
		endcase
	end

endmodule
`default_nettype wire
